>>> src/asp_pkg.sv
`default_nettype none

package asp_pkg;

   // Width of the byte position counter and the committed match position.
   localparam int POSITION_BITS = 24;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] MIN_DISTANCE = POSITION_BITS'(4);

   // Byte codes of the pattern and of the package encoding.
   localparam logic [7:0] NAME_PREFIX  = 8'h08;
   localparam logic [7:0] ROOT_CHAR    = 8'h5C;
   localparam logic [7:0] UNDERSCORE   = 8'h5F;
   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_5       = 8'h35;
   localparam logic [7:0] PACKAGE_OP   = 8'h12;
   localparam logic [7:0] BYTE_PREFIX  = 8'h0A;

   localparam int HISTORY_DEPTH = 5;

   typedef enum logic [3:0] {
      PH_SEARCH   = 4'd0,
      PH_AWAIT    = 4'd1,
      PH_LENGTH   = 4'd2,
      PH_SKIP     = 4'd3,
      PH_A_OR_PFX = 4'd4,
      PH_A        = 4'd5,
      PH_B_OR_PFX = 4'd6,
      PH_B        = 4'd7,
      PH_DONE     = 4'd8
   } phase_type;

   typedef struct packed {
      logic       found;
      logic [2:0] sleep_type_a;
      logic [2:0] sleep_type_b;
   } result_type;

   // Common control for the datapath modules: one byte taken this cycle.
   typedef struct packed {
      logic       step;
      logic       last;
      logic [7:0] data_byte;
   } step_type;

endpackage

`default_nettype wire

>>> src/asp_match.sv
`default_nettype none

module asp_match (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire asp_pkg::step_type ctl,
   output logic                   hit
);

   logic [7:0] recent_ff [asp_pkg::HISTORY_DEPTH];
   logic [7:0] recent_in [asp_pkg::HISTORY_DEPTH];

   // Detect the name with its prefix, with or without the root character.
   always_comb begin
      hit = (ctl.data_byte == asp_pkg::UNDERSCORE) &&
            (recent_ff[0] == asp_pkg::CHAR_5) &&
            (recent_ff[1] == asp_pkg::CHAR_S) &&
            (recent_ff[2] == asp_pkg::UNDERSCORE) &&
            ((recent_ff[3] == asp_pkg::NAME_PREFIX) ||
             ((recent_ff[4] == asp_pkg::NAME_PREFIX) &&
              (recent_ff[3] == asp_pkg::ROOT_CHAR)));
   end

   // Shift the history, clear it at the end of a body.
   always_comb begin
      recent_in[0] = ctl.data_byte;
      for (int i = 1; i < asp_pkg::HISTORY_DEPTH; i++) begin
         recent_in[i] = recent_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < asp_pkg::HISTORY_DEPTH; i++) begin
            recent_ff[i] <= 8'h00;
         end
      end else if (ctl.step) begin
         for (int i = 0; i < asp_pkg::HISTORY_DEPTH; i++) begin
            recent_ff[i] <= ctl.last ? 8'h00 : recent_in[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> src/asp_parse.sv
`default_nettype none

module asp_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire asp_pkg::step_type   ctl,
   input  wire logic                hit,
   output asp_pkg::result_type      res
);

   asp_pkg::phase_type                 phase_ff, phase_in;
   logic [2:0]                         skip_ff, skip_in;
   logic [asp_pkg::POSITION_BITS-1:0]  pos_ff, pos_in;
   logic [asp_pkg::POSITION_BITS-1:0]  start_ff, start_in;
   logic [asp_pkg::POSITION_BITS-1:0]  distance;
   logic [2:0]                         type_a_ff, type_a_in;
   logic [2:0]                         type_b_ff, type_b_in;
   logic                               found;

   // Advance the parse phase for the byte in hand.
   always_comb begin
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      start_in  = start_ff;
      type_a_in = type_a_ff;
      type_b_in = type_b_ff;
      case (phase_ff)
         asp_pkg::PH_SEARCH: begin
            if (hit) begin
               phase_in = asp_pkg::PH_AWAIT;
            end
         end
         asp_pkg::PH_AWAIT: begin
            if (ctl.data_byte == asp_pkg::PACKAGE_OP) begin
               start_in  = pos_ff;
               type_a_in = 3'd0;
               type_b_in = 3'd0;
               phase_in  = asp_pkg::PH_LENGTH;
            end else begin
               phase_in = asp_pkg::PH_SEARCH;
            end
         end
         asp_pkg::PH_LENGTH: begin
            skip_in  = {1'b0, ctl.data_byte[7:6]} + 3'd1;
            phase_in = asp_pkg::PH_SKIP;
         end
         asp_pkg::PH_SKIP: begin
            skip_in = skip_ff - 3'd1;
            if (skip_in == 3'd0) begin
               phase_in = asp_pkg::PH_A_OR_PFX;
            end
         end
         asp_pkg::PH_A_OR_PFX: begin
            if (ctl.data_byte == asp_pkg::BYTE_PREFIX) begin
               phase_in = asp_pkg::PH_A;
            end else begin
               type_a_in = ctl.data_byte[2:0];
               phase_in  = asp_pkg::PH_B_OR_PFX;
            end
         end
         asp_pkg::PH_A: begin
            type_a_in = ctl.data_byte[2:0];
            phase_in  = asp_pkg::PH_B_OR_PFX;
         end
         asp_pkg::PH_B_OR_PFX: begin
            if (ctl.data_byte == asp_pkg::BYTE_PREFIX) begin
               phase_in = asp_pkg::PH_B;
            end else begin
               type_b_in = ctl.data_byte[2:0];
               phase_in  = asp_pkg::PH_DONE;
            end
         end
         asp_pkg::PH_B: begin
            type_b_in = ctl.data_byte[2:0];
            phase_in  = asp_pkg::PH_DONE;
         end
         default: begin
         end
      endcase
   end

   // Advance the byte position, hold at the top.
   assign pos_in = (pos_ff == asp_pkg::POS_MAX) ? pos_ff
                 : pos_ff + asp_pkg::POSITION_BITS'(1);

   // Report a package only when it lies far enough from the end.
   assign distance = pos_ff - start_in;
   assign found = ((phase_in == asp_pkg::PH_B_OR_PFX) ||
                   (phase_in == asp_pkg::PH_B) ||
                   (phase_in == asp_pkg::PH_DONE)) &&
                  (pos_ff >= start_in) && (distance >= asp_pkg::MIN_DISTANCE);

   always_comb begin
      res.found        = found;
      res.sleep_type_a = found ? type_a_in : 3'd0;
      res.sleep_type_b = found ? type_b_in : 3'd0;
   end

   // Update on each accepted byte, return to reset after the last one.
   always_ff @(posedge clock) begin
      if (reset || (ctl.step && ctl.last)) begin
         phase_ff  <= asp_pkg::PH_SEARCH;
         skip_ff   <= 3'd0;
         pos_ff    <= '0;
         start_ff  <= '0;
         type_a_ff <= 3'd0;
         type_b_ff <= 3'd0;
      end else if (ctl.step) begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         type_a_ff <= type_a_in;
         type_b_ff <= type_b_in;
      end
   end

endmodule

`default_nettype wire

>>> src/aml_sleep_state_package_finder.sv
// Channel   Direction  Ports                                      Transaction
// req       in         req_data_byte, req_last                    one body byte
// rsp       out        rsp_found, rsp_sleep_type_a/_b             one per body
//
// One byte is taken per cycle while req_ready is high; the parse phase and byte
// history update in the cycle of acceptance, and the result is registered into
// the output register as the last byte of a body is accepted.
// Synchronous active-high reset clears the parser, history and output valid.
// req_ready drops only while a result waits in the output register and
// rsp_ready is low.
`default_nettype none

module aml_sleep_state_package_finder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_found,
   output logic [2:0]      rsp_sleep_type_a,
   output logic [2:0]      rsp_sleep_type_b
);

   asp_pkg::step_type   ctl;
   asp_pkg::result_type res;
   asp_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit;

   // Accept a transaction whenever the output register is free or draining.
   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign ctl.step      = req_valid && req_ready;
   assign ctl.last      = req_last;
   assign ctl.data_byte = req_data_byte;

   asp_match u_match (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hit   (hit)
   );

   asp_parse u_parse (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hit   (hit),
      .res   (res)
   );

   // Hold the result until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.step && ctl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step && ctl.last) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_sleep_type_a = rsp_ff.sleep_type_a;
   assign rsp_sleep_type_b = rsp_ff.sleep_type_b;

endmodule

`default_nettype wire

>>> src/asp_checker.sv
`default_nettype none

module asp_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_found,
   input  wire logic [2:0] rsp_sleep_type_a,
   input  wire logic [2:0] rsp_sleep_type_b
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_sleep_type_a) && $stable(rsp_sleep_type_b))
      else $error("stalled result changed");

   // A result that reports not found carries zero types.
   a_zero_types: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_sleep_type_a == 3'd0 && rsp_sleep_type_b == 3'd0)
      else $error("types set on a not-found result");

   // The last byte of a body yields a result in the next cycle.
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("no result after last byte");

   // A byte that is not last invents no result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_last) |=> !rsp_valid)
      else $error("result without last byte");

   // Input stalls only behind a waiting result.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without cause");

endmodule

bind aml_sleep_state_package_finder asp_checker u_asp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_sleep_type_a (rsp_sleep_type_a),
   .rsp_sleep_type_b (rsp_sleep_type_b)
);

`default_nettype wire
